>>> hdl/oaht_pkg.sv
// Package with request and result types, command and status structs, and result codes.
`timescale 1ns / 1ps
package oaht_pkg;

    localparam int KEY_W     = 31;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 5;
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = 8;
    localparam int PAD_W     = MOD_BITS * MOD_STEPS;
    localparam int MSTEP_W   = $clog2(MOD_STEPS);

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } rsp_t;

    typedef struct packed {
        logic                clr_step;
        logic                load;
        logic                mod_step;
        logic                probe_start;
        logic                advance;
        logic                write_key;
        logic                res_load;
        logic                res_use_slot;
        logic [STATUS_W-1:0] res_status;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_search;
        logic key_zero;
        logic mod_last;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic res_free;
    } dp_stat_t;

endpackage

>>> hdl/oaht_datapath.sv
// Datapath with slot memory, key remainder unit, probe index and result register.
`timescale 1ns / 1ps
module oaht_datapath import oaht_pkg::*; #(
    parameter int TABLE_SIZE = 31
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  req_t     s_req,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output logic     m_valid,
    input  logic     m_ready,
    output rsp_t     m_rsp
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int REM_W = $clog2(TABLE_SIZE) + 1;
    localparam logic [REM_W-1:0] SIZE_R = REM_W'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    logic [KEY_W-1:0] mem [TABLE_SIZE];
    logic [KEY_W-1:0] rdata_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               cmd_reg;
    logic [PAD_W-1:0]   sh_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [MSTEP_W-1:0] mstep_reg;
    logic               m_valid_reg;
    rsp_t               rsp_reg;
    logic [IDX_W+SLOT_W-1:0] idx_ext;

    always_comb begin
        logic [REM_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < MOD_BITS; i++) begin
            r = {r[REM_W-2:0], sh_reg[PAD_W-1-i]};
            if (r >= SIZE_R) begin
                r = r - SIZE_R;
            end
        end
        rem_next = r;
    end

    assign idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    always_comb begin
        if (cmd.probe_start) begin
            rd_addr = rem_next[IDX_W-1:0];
        end else if (cmd.advance) begin
            rd_addr = idx_next;
        end else begin
            rd_addr = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mem[idx_reg] <= '0;
        end else if (cmd.write_key) begin
            mem[idx_reg] <= key_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            cnt_reg     <= '0;
            mstep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                idx_reg <= idx_next;
            end else if (cmd.probe_start) begin
                idx_reg <= rem_next[IDX_W-1:0];
                cnt_reg <= '0;
            end else if (cmd.advance) begin
                idx_reg <= idx_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.load) begin
                mstep_reg <= '0;
            end else if (cmd.mod_step) begin
                mstep_reg <= mstep_reg + 1'b1;
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign idx_ext = {{SLOT_W{1'b0}}, idx_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= s_req.key;
            cmd_reg <= s_req.cmd;
            sh_reg  <= {{(PAD_W - KEY_W){1'b0}}, s_req.key};
            rem_reg <= '0;
        end else if (cmd.mod_step) begin
            sh_reg  <= sh_reg << MOD_BITS;
            rem_reg <= rem_next;
        end
        if (cmd.res_load) begin
            rsp_reg.status <= cmd.res_status;
            rsp_reg.slot   <= cmd.res_use_slot ? idx_ext[SLOT_W-1:0] : '0;
        end
    end

    assign stat.clr_last   = (idx_reg == LAST_IDX);
    assign stat.is_search  = (cmd_reg == CMD_SEARCH);
    assign stat.key_zero   = (key_reg == '0);
    assign stat.mod_last   = (mstep_reg == MSTEP_W'(MOD_STEPS - 1));
    assign stat.slot_empty = (rdata_reg == '0);
    assign stat.slot_match = (rdata_reg == key_reg);
    assign stat.probe_last = (cnt_reg == LAST_IDX);
    assign stat.res_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= LAST_IDX)
        else $error("probe index out of range");

    a_no_zero_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_key |-> (key_reg != '0) && (rdata_reg == '0))
        else $error("key written over occupied slot or key is zero");

    a_found_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load && (cmd.res_status == STAT_FOUND) |-> rdata_reg == key_reg)
        else $error("found result without matching slot");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> !m_valid_reg || m_ready)
        else $error("result loaded over pending result");

endmodule

>>> hdl/oaht_ctrl.sv
// Controller state machine sequencing clear, hash, probe and result.
`timescale 1ns / 1ps
module oaht_ctrl import oaht_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_HASH  = 4'b0100,
        ST_PROBE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        logic                done;
        logic                use_slot;
        logic                wr;
        logic [STATUS_W-1:0] st;
        done       = 1'b0;
        use_slot   = 1'b0;
        wr         = 1'b0;
        st         = STAT_NOT_FOUND;
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (stat.key_zero) begin
                    cmd.res_status = STAT_INVALID;
                    if (stat.res_free) begin
                        cmd.res_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.mod_step = 1'b1;
                    if (stat.mod_last) begin
                        cmd.probe_start = 1'b1;
                        state_next      = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (!stat.is_search) begin
                    if (stat.slot_empty) begin
                        done     = 1'b1;
                        use_slot = 1'b1;
                        wr       = 1'b1;
                        st       = STAT_INSERTED;
                    end else if (stat.probe_last) begin
                        done = 1'b1;
                        st   = STAT_FULL;
                    end
                end else begin
                    if (stat.slot_empty) begin
                        done = 1'b1;
                        st   = STAT_NOT_FOUND;
                    end else if (stat.slot_match) begin
                        done     = 1'b1;
                        use_slot = 1'b1;
                        st       = STAT_FOUND;
                    end else if (stat.probe_last) begin
                        done = 1'b1;
                        st   = STAT_NOT_FOUND;
                    end
                end
                cmd.res_status   = st;
                cmd.res_use_slot = use_slot;
                if (!done) begin
                    cmd.advance = 1'b1;
                end else if (stat.res_free) begin
                    cmd.res_load  = 1'b1;
                    cmd.write_key = wr;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_HASH)
        else $error("accepted request did not start hashing");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) && stat.clr_last |=> state_reg == ST_IDLE)
        else $error("clearing pass did not finish");

    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.advance, cmd.res_load, cmd.probe_start, cmd.clr_step}))
        else $error("conflicting datapath commands");

endmodule

>>> hdl/open_addressing_hash_table_top.sv
// Top level: linear probing hash table with request and result channels.
// After reset the slot memory is cleared one slot per cycle, over all TABLE_SIZE slots; no request taken.
// A request is taken in idle, its key remainder is computed in the hash state, then one slot is probed per cycle.
// A request probes 1 to TABLE_SIZE slots before its result; key zero gets an invalid result without probing.
// Requests are taken one at a time: a request is hashed and probed to its end before the next is taken,
// as the table has a single read port. The result register lets the next request start while a result waits.
`timescale 1ns / 1ps
module open_addressing_hash_table_top import oaht_pkg::*; #(
    parameter int TABLE_SIZE = 31
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    oaht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    oaht_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

endmodule
